// ===== hw/rtl/sthe_pkg.sv =====
package sthe_pkg;

    localparam int VAL_W     = 48;
    localparam int STEP_W    = 32;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 6;
    localparam int WGT_W     = 17;
    localparam int WGT_FRAC  = 16;
    localparam int CFG_IDX_W = 3;

    // divisor of the linear term of the mapping
    localparam int DIV_K       = 1000;
    // shift out the factor of eight, then multiply by ceil(2^50 / 125)
    localparam int DIV_K_PRE   = 3;
    localparam int DIV_K_SHIFT = 50;
    localparam int DIV_RECIP_W = 44;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 44'd9007199254741;

    localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_CONTRACTIVE_ON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT      = 3'd4;

    typedef struct packed {
        logic                     contractive_on;
        logic signed [VAL_W-1:0]  range_min;
        logic signed [VAL_W-1:0]  range_max;
        logic [STEP_W-1:0]        bin_step;
        logic [CNT_W-1:0]         bin_count;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        contractive_on: 1'b0,
        range_min:      -48'sd2031616,
        range_max:      48'sd2097152,
        bin_step:       32'd65536,
        bin_count:      7'd64
    };

endpackage

// ===== hw/rtl/sthe_in_if.sv =====
interface sthe_in_if;
    import sthe_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);

endinterface

// ===== hw/rtl/sthe_out_if.sv =====
interface sthe_out_if;
    import sthe_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] bin_index;
    logic [WGT_W-1:0] bin_weight;
    logic             last_bin;

    modport source (output valid, output bin_index, output bin_weight, output last_bin,
                    input ready);
    modport sink (input valid, input bin_index, input bin_weight, input last_bin,
                  output ready);

endinterface

// ===== hw/rtl/sthe_contract.sv =====
module sthe_contract #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sthe_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [sthe_pkg::VAL_W-1:0] in_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sthe_pkg::VAL_W-1:0]       out_dist
);
    import sthe_pkg::*;

    localparam int RW = (VAL_W + FRAC_BITS + 1) / 2;
    localparam int XW = VAL_W + 1;
    localparam int CW = $clog2(VAL_W);
    localparam int KW = 16;
    localparam int PW = VAL_W + DIV_RECIP_W;
    localparam logic [CW-1:0]    LAST_STEP = CW'(VAL_W - 1);
    localparam logic [CW-1:0]    SQ_STEPS  = CW'(RW);
    localparam logic [CW-1:0]    DIV_STEPS = CW'(VAL_W / KW);
    localparam logic [VAL_W-1:0] ONE       = VAL_W'(64'd1 << FRAC_BITS);

    logic                    run_reg;
    logic                    map_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    neg_reg;
    logic [2*RW-1:0]         rad_reg;
    logic [RW:0]             rem_reg;
    logic [RW-1:0]           root_reg;
    logic [VAL_W-1:0]        dq_reg;
    logic [PW-1:0]           acc_reg;
    logic                    x_valid_reg;
    logic signed [XW-1:0]    x_reg;
    logic                    out_valid_reg;
    logic [VAL_W-1:0]        dist_reg;

    logic                    in_fire;
    logic                    x_move;
    logic                    in_neg;
    logic [VAL_W-1:0]        in_mag;
    logic [2*RW-1:0]         rad_init;
    logic                    sq_active;
    logic [RW+2:0]           sq_r2;
    logic [RW+2:0]           sq_trial;
    logic                    sq_ge;
    logic [RW:0]             rem_next;
    logic [RW-1:0]           root_next;
    logic                    div_active;
    logic [KW+DIV_RECIP_W-1:0] part;
    logic [PW-1:0]           acc_next;
    logic signed [XW-1:0]    m_val;
    logic signed [XW-1:0]    x_map;
    logic signed [XW-1:0]    lo;
    logic signed [XW-1:0]    hi;
    logic signed [XW-1:0]    c1;
    logic signed [XW-1:0]    c2;
    logic signed [XW-1:0]    diff;
    logic [VAL_W-1:0]        dist_next;

    assign x_move   = x_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !run_reg && !map_reg && (!x_valid_reg || x_move);
    assign in_fire  = in_valid && in_ready;

    assign in_neg   = in_value[VAL_W-1];
    assign in_mag   = in_neg ? VAL_W'(-in_value) : VAL_W'(in_value);
    assign rad_init = (2*RW)'({in_mag + ONE, {FRAC_BITS{1'b0}}});

    // square root, two radicand bits per step
    assign sq_active = cnt_reg < SQ_STEPS;
    assign sq_r2     = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge     = sq_r2 >= sq_trial;
    assign rem_next  = (RW+1)'(sq_ge ? sq_r2 - sq_trial : sq_r2);
    assign root_next = {root_reg[RW-2:0], sq_ge};

    // magnitude divided by the constant, reciprocal product one slice per step
    assign div_active = cnt_reg < DIV_STEPS;
    assign part       = (KW+DIV_RECIP_W)'(dq_reg[VAL_W-1 -: KW])
                        * (KW+DIV_RECIP_W)'(DIV_RECIP);
    assign acc_next   = {acc_reg[PW-KW-1:0], {KW{1'b0}}} + PW'(part);

    assign m_val = XW'(root_reg) - XW'(ONE) + XW'(acc_reg[PW-1:DIV_K_SHIFT]);
    assign x_map = neg_reg ? -m_val : m_val;

    assign lo        = $signed({cfg.range_min[VAL_W-1], cfg.range_min});
    assign hi        = $signed({cfg.range_max[VAL_W-1], cfg.range_max});
    assign c1        = (x_reg < lo) ? lo : x_reg;
    assign c2        = (c1 > hi) ? hi : c1;
    assign diff      = c2 - lo;
    assign dist_next = (c2 > lo) ? diff[VAL_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            map_reg       <= 1'b0;
            cnt_reg       <= '0;
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            map_reg <= 1'b0;
            if (in_fire)
            begin
                if (cfg.contractive_on)
                begin
                    run_reg <= 1'b1;
                    cnt_reg <= '0;
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    run_reg <= 1'b0;
                    map_reg <= 1'b1;
                end
            end

            if ((in_fire && !cfg.contractive_on) || map_reg)
                x_valid_reg <= 1'b1;
            else if (x_move)
                x_valid_reg <= 1'b0;

            if (x_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            neg_reg  <= in_neg;
            rad_reg  <= rad_init;
            rem_reg  <= '0;
            root_reg <= '0;
            dq_reg   <= in_mag >> DIV_K_PRE;
            acc_reg  <= '0;
            if (!cfg.contractive_on)
                x_reg <= $signed({in_value[VAL_W-1], in_value});
        end
        else if (run_reg)
        begin
            if (sq_active)
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
            end
            if (div_active)
            begin
                dq_reg  <= dq_reg << KW;
                acc_reg <= acc_next;
            end
        end
        if (map_reg)
            x_reg <= x_map;
        if (x_move)
            dist_reg <= dist_next;
    end

    assign out_valid = out_valid_reg;
    assign out_dist  = dist_reg;

endmodule

// ===== hw/rtl/sthe_divide.sv =====
module sthe_divide #(
    parameter int MAX_BINS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sthe_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sthe_pkg::VAL_W-1:0]          in_dist,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [$clog2(MAX_BINS+1)-1:0]       out_lower,
    output logic [sthe_pkg::WGT_FRAC-1:0]       out_up
);
    import sthe_pkg::*;

    localparam int QW = VAL_W + WGT_FRAC;
    localparam int CW = $clog2(QW);
    localparam int LW = $clog2(MAX_BINS + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);

    logic                  run_reg;
    logic [CW-1:0]         cnt_reg;
    logic [QW-1:0]         qd_reg;
    logic [STEP_W-1:0]     rem_reg;
    logic                  out_valid_reg;
    logic [LW-1:0]         lower_reg;
    logic [WGT_FRAC-1:0]   up_reg;

    logic                  in_fire;
    logic                  done;
    logic [STEP_W-1:0]     step_eff;
    logic [STEP_W:0]       t;
    logic                  ge;
    logic [STEP_W-1:0]     rem_next;
    logic [QW-1:0]         qd_next;
    logic [VAL_W-1:0]      q_int;
    logic [LW-1:0]         lower_next;

    assign in_ready = !run_reg && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign done     = run_reg && (cnt_reg == LAST_STEP);

    assign step_eff = (cfg.bin_step == '0) ? STEP_W'(1) : cfg.bin_step;
    assign t        = {rem_reg, qd_reg[QW-1]};
    assign ge       = t >= {1'b0, step_eff};
    assign rem_next = STEP_W'(ge ? t - {1'b0, step_eff} : t);
    assign qd_next  = {qd_reg[QW-2:0], ge};

    // any lower bin at or past the end lights no bin
    assign q_int      = qd_next[QW-1:WGT_FRAC];
    assign lower_next = (q_int >= VAL_W'(MAX_BINS)) ? LW'(MAX_BINS) : LW'(q_int);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (done)
                    run_reg <= 1'b0;
            end

            if (done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            qd_reg  <= {in_dist, {WGT_FRAC{1'b0}}};
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            qd_reg  <= qd_next;
            rem_reg <= rem_next;
        end
        if (done)
        begin
            lower_reg <= lower_next;
            up_reg    <= qd_next[WGT_FRAC-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_lower = lower_reg;
    assign out_up    = up_reg;

endmodule

// ===== hw/rtl/sthe_queue.sv =====
module sthe_queue #(
    parameter int W     = 23,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [FW-1:0] fill_reg;

    logic push;
    logic pop;

    assign in_ready  = fill_reg != FW'(DEPTH);
    assign out_valid = fill_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_data;
    end

endmodule

// ===== hw/rtl/sthe_emit.sv =====
module sthe_emit #(
    parameter int MAX_BINS = 64
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  sthe_pkg::cfg_t                                   cfg,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic [$clog2(MAX_BINS+1)+sthe_pkg::WGT_FRAC-1:0] in_data,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic [sthe_pkg::IDX_W-1:0]                       out_index,
    output logic [sthe_pkg::WGT_W-1:0]                       out_weight,
    output logic                                             out_last
);
    import sthe_pkg::*;

    localparam int LW = $clog2(MAX_BINS + 1);
    localparam int IW = $clog2(MAX_BINS);

    logic [IW-1:0]       i_reg;
    logic                ov_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [WGT_W-1:0]    wgt_reg;
    logic                last_reg;

    logic [LW-1:0]       lower;
    logic [WGT_FRAC-1:0] up;
    logic [LW-1:0]       n;
    logic                n_zero;
    logic                slot_free;
    logic                is_last;
    logic                beat;
    logic                hit_lo;
    logic                hit_up;
    logic [WGT_W-1:0]    wgt_next;

    assign lower = in_data[LW+WGT_FRAC-1:WGT_FRAC];
    assign up    = in_data[WGT_FRAC-1:0];

    assign n = (32'(cfg.bin_count) > 32'(MAX_BINS)) ? LW'(MAX_BINS) : LW'(cfg.bin_count);

    assign n_zero    = n == '0;
    assign slot_free = !ov_reg || out_ready;
    assign is_last   = (LW'(i_reg) + LW'(1)) == n;
    assign beat      = in_valid && !n_zero && slot_free;
    assign in_ready  = n_zero || (slot_free && is_last);

    assign hit_lo = LW'(i_reg) == lower;
    assign hit_up = (LW+1)'(i_reg) == ((LW+1)'(lower) + (LW+1)'(1));

    always_comb
    begin
        wgt_next = '0;
        if (hit_lo)
            wgt_next = WGT_ONE - WGT_W'(up);
        else if (hit_up)
            wgt_next = WGT_W'(up);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (beat)
            begin
                i_reg  <= is_last ? '0 : i_reg + 1'b1;
                ov_reg <= 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            idx_reg  <= IDX_W'(i_reg);
            wgt_reg  <= wgt_next;
            last_reg <= is_last;
        end
    end

    assign out_valid  = ov_reg;
    assign out_index  = idx_reg;
    assign out_weight = wgt_reg;
    assign out_last   = last_reg;

endmodule

// ===== hw/rtl/scaled_two_hot_value_encoder.sv =====
// Two-hot value encoder.
// in_ch carries one signed sample_value per beat. For each accepted beat the block
// sends bin_count beats on out_ch (capped at MAX_BINS), bin_index counting up from
// zero, with last_bin set on the final one. At most two consecutive bins carry a
// nonzero bin_weight. A bin_count of zero consumes the sample without output.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// With the contractive mapping on, the square root and the divide by 1000 run
// inside a 48-step loop before the bin divide; then the bin divide produces one
// quotient bit per cycle over 64 steps. The bin divide takes no new sample until
// its last result has moved on; the mapping loop of the next sample overlaps it.
// A two-entry queue sits between the divide and the output sequencer, and every
// stage ends in a register, so a stalled receiver holds the current beat and
// backs up into in_ch without loss.
// Reset clears all control state and loads the default register values.
module scaled_two_hot_value_encoder #(
    parameter int MAX_BINS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sthe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sthe_pkg::VAL_W-1:0]          cfg_data,
    sthe_in_if.sink                             in_ch,
    sthe_out_if.source                          out_ch
);
    import sthe_pkg::*;

    localparam int LW = $clog2(MAX_BINS + 1);
    localparam int QW = LW + WGT_FRAC;

    cfg_t                cfg_reg;

    logic                map_valid;
    logic                map_ready;
    logic [VAL_W-1:0]    map_dist;
    logic                div_valid;
    logic                div_ready;
    logic [LW-1:0]       div_lower;
    logic [WGT_FRAC-1:0] div_up;
    logic                q_valid;
    logic                q_ready;
    logic [QW-1:0]       q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RST;
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONTRACTIVE_ON: cfg_reg.contractive_on <= cfg_data[0];
                REG_RANGE_MIN:      cfg_reg.range_min      <= cfg_data;
                REG_RANGE_MAX:      cfg_reg.range_max      <= cfg_data;
                REG_BIN_STEP:       cfg_reg.bin_step       <= cfg_data[STEP_W-1:0];
                REG_BIN_COUNT:      cfg_reg.bin_count      <= cfg_data[CNT_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    sthe_contract #(
        .FRAC_BITS (FRAC_BITS)
    ) u_contract (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_value  (in_ch.sample_value),
        .out_valid (map_valid),
        .out_ready (map_ready),
        .out_dist  (map_dist)
    );

    sthe_divide #(
        .MAX_BINS (MAX_BINS)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (map_valid),
        .in_ready  (map_ready),
        .in_dist   (map_dist),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_lower (div_lower),
        .out_up    (div_up)
    );

    sthe_queue #(
        .W     (QW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   ({div_lower, div_up}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    sthe_emit #(
        .MAX_BINS (MAX_BINS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_data    (q_data),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_index  (out_ch.bin_index),
        .out_weight (out_ch.bin_weight),
        .out_last   (out_ch.last_bin)
    );

endmodule
